[src/lpd_pkg.sv]
// Shared widths, constants and register codes for the lithostatic pressure core.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none

package lpd_pkg;

	localparam int TABLE_ENTRIES_DEF = 128;

	localparam int OP_W      = 1;
	localparam int IDX_W     = 7;
	localparam int DEPTH_W   = 20;
	localparam int DENS_W    = 20;
	localparam int QDEPTH_W  = 21;
	localparam int PRESS_W   = 40;
	localparam int ENTRIES_W = 8;
	localparam int GRAV_W    = 18;

	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 32;

	localparam logic [OP_W-1:0] OP_WRITE = 1'b0;
	localparam logic [OP_W-1:0] OP_QUERY = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ENTRIES = 4'd0,
		CFG_GRAVITY = 4'd1
	} cfg_reg_t;

	localparam logic [ENTRIES_W-1:0] ENTRIES_RESET = 8'd2;
	localparam logic [GRAV_W-1:0]    GRAV_RESET    = 18'd98100;

	// density unit is 0.001 kg/m3, gravity unit 1e-4 m/s2, area sum is doubled
	localparam int DENSITY_SCALE = 1000;
	localparam int DIVR_W        = 21;
	localparam logic [DIVR_W-1:0] PRESS_DIVISOR = DIVR_W'(2 * DENSITY_SCALE * DENSITY_SCALE);

	// divisor is 2^7 * 15625: drop seven bits, then divide by the odd part one
	// 16-bit quotient digit at a time with a reciprocal multiply
	localparam int PRESS_SHIFT = 7;
	localparam int PRESS_ODD   = int'(PRESS_DIVISOR >> PRESS_SHIFT);
	localparam int PDIG_W      = 16;
	localparam int PREM_W      = 14;
	localparam int PDV_W       = PREM_W + PDIG_W;
	localparam int RECIP_SH    = 44;
	localparam int RECIP_W     = 31;
	localparam logic [RECIP_W-1:0] PRESS_RECIP =
		RECIP_W'(((64'd1 << RECIP_SH) + 64'(PRESS_ODD) - 64'd1) / 64'(PRESS_ODD));

	// one table entry in memory: depth in the upper half, density in the lower
	localparam int ENTRY_W = DEPTH_W + DENS_W;

	// thickness (20b) times density sum (21b)
	localparam int PROD_W = DEPTH_W + DENS_W + 1;

	// interpolation dividend is partial thickness times density step
	localparam int INTERP_W = DEPTH_W + DENS_W;

endpackage

`default_nettype wire

[src/lpd_in_if.sv]
// Input channel: table writes and pressure queries, valid/ready handshake.
// Depends on lpd_pkg for field widths.
`default_nettype none

interface lpd_in_if;
	logic                                 valid;
	logic                                 ready;
	logic [lpd_pkg::OP_W-1:0]             operation;
	logic [lpd_pkg::IDX_W-1:0]            entry_index;
	logic [lpd_pkg::DEPTH_W-1:0]          entry_depth;
	logic [lpd_pkg::DENS_W-1:0]           entry_density;
	logic signed [lpd_pkg::QDEPTH_W-1:0]  query_depth;

	modport source (output valid, output operation, output entry_index,
		output entry_depth, output entry_density, output query_depth, input ready);
	modport sink (input valid, input operation, input entry_index,
		input entry_depth, input entry_density, input query_depth, output ready);
endinterface

`default_nettype wire

[src/lpd_out_if.sv]
// Result channel: pressure and range flag, valid/ready handshake.
// Depends on lpd_pkg for field widths.
`default_nettype none

interface lpd_out_if;
	logic                         valid;
	logic                         ready;
	logic [lpd_pkg::PRESS_W-1:0]  pressure;
	logic                         out_of_range;

	modport source (output valid, output pressure, output out_of_range, input ready);
	modport sink (input valid, input pressure, input out_of_range, output ready);
endinterface

`default_nettype wire

[src/lpd_cfg_if.sv]
// Configuration write channel: register index and data, valid/ready handshake.
// Depends on lpd_pkg for field widths.
`default_nettype none

interface lpd_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [lpd_pkg::CFG_IDX_W-1:0]   index;
	logic [lpd_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[src/lithostatic_pressure_from_density_table_core.sv]
// Lithostatic pressure core: profile table memory, segment walk, interpolation and pressure dividers.
// Depends on lpd_pkg, lpd_in_if, lpd_out_if and lpd_cfg_if.
//
//   channel | modport | payload                                         | transaction
//   req     | sink    | operation, entry_index, entry_depth,            | table write or query
//           |         | entry_density, query_depth                      |
//   rsp     | source  | pressure, out_of_range                          | one per query
//   cfg     | sink    | index, data                                     | register write
//
// A table write is stored at its transaction. A query stalls the input from its transaction
// until its result is loaded: it walks the segments (one per cycle, set by the single table
// read port), runs the interpolation divide when the depth falls inside a segment, and then
// divides by 2000000 in four quotient digits. One item is in work at a time; a finished
// result waits in the output register while the next item is accepted, and a query holds
// in its last state while that register is full. Reset clears control only.
`default_nettype none

module lithostatic_pressure_from_density_table_core #(
	parameter int TABLE_ENTRIES = lpd_pkg::TABLE_ENTRIES_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	lpd_in_if.sink     req,
	lpd_out_if.source  rsp,
	lpd_cfg_if.sink    cfg
);

	localparam int AW     = $clog2(TABLE_ENTRIES);
	localparam int CW     = $clog2(TABLE_ENTRIES + 1);
	localparam int ACC_W  = lpd_pkg::PROD_W + $clog2(TABLE_ENTRIES);
	localparam int LO_W   = ACC_W / 2;
	localparam int HI_W   = ACC_W - LO_W;
	localparam int DQ_W   = ACC_W + lpd_pkg::GRAV_W;
	localparam int CNT_W  = $clog2(DQ_W + 1);
	localparam int DW     = lpd_pkg::DEPTH_W;
	localparam int RW     = lpd_pkg::DENS_W;
	localparam int QW     = lpd_pkg::QDEPTH_W;
	localparam int VW     = lpd_pkg::DIVR_W;
	localparam int IW     = lpd_pkg::INTERP_W;
	localparam int PW     = lpd_pkg::PRESS_W;
	localparam int PD_N   = (DQ_W - lpd_pkg::PRESS_SHIFT + lpd_pkg::PDIG_W - 1) / lpd_pkg::PDIG_W;
	localparam int PQ_W   = PD_N * lpd_pkg::PDIG_W;
	localparam int PM_W   = lpd_pkg::PDV_W + lpd_pkg::RECIP_W;

	typedef enum logic [9:0] {
		ST_IDLE = 10'b0000000001,
		ST_WALK = 10'b0000000010,
		ST_DIV  = 10'b0000000100,
		ST_PART = 10'b0000001000,
		ST_SUMW = 10'b0000010000,
		ST_PMUL = 10'b0000100000,
		ST_PADD = 10'b0001000000,
		ST_PDIV = 10'b0010000000,
		ST_PREM = 10'b0100000000,
		ST_FIN  = 10'b1000000000
	} state_t;

	state_t state_q;

	logic [lpd_pkg::ENTRIES_W-1:0] entries_q;
	logic [lpd_pkg::GRAV_W-1:0]    gravity_q;

	logic [lpd_pkg::ENTRY_W-1:0] tbl_mem [TABLE_ENTRIES];
	logic [lpd_pkg::ENTRY_W-1:0] rd_data_q;
	logic [lpd_pkg::ENTRY_W-1:0] prev_q;
	logic                        rd_en;
	logic [AW-1:0]               rd_addr;
	logic                        wr_en;
	logic [AW-1:0]               wr_addr;
	logic [AW+lpd_pkg::IDX_W-1:0] wr_addr_wide;

	logic                  have_prev_q;
	logic [CW-1:0]         nxt_q;
	logic [CW-1:0]         live_n;
	logic [31:0]           ent_w;
	logic [CNT_W-1:0]      cnt_q;
	logic                  oor_q;

	logic [QW-1:0]         q_q;
	logic [QW-1:0]         q_abs;
	logic [ACC_W-1:0]      acc_q;
	logic [lpd_pkg::PROD_W-1:0] prod_s1;
	logic                  prod_vld_s1;
	logic [lpd_pkg::PROD_W-1:0] prod_d;
	logic                  prod_load;

	logic [DW-1:0] z1, z2, thick, span;
	logic [RW-1:0] r1, r2, dmag;
	logic [QW-1:0] part_full;
	logic          walk_found, walk_inside, walk_last;
	logic [IW-1:0] ip_prod;

	logic [DW-1:0] part_q;
	logic [RW-1:0] r1_q;
	logic          up_q;
	logic [RW-1:0] rq;

	logic [DQ_W-1:0] dq_q;
	logic [VW-1:0]   rem_q;
	logic [VW-1:0]   divr_q;
	logic [VW:0]     div_t;
	logic [VW:0]     div_diff;
	logic            div_ge;

	logic [LO_W+lpd_pkg::GRAV_W-1:0] plo_q;
	logic [HI_W+lpd_pkg::GRAV_W-1:0] phi_q;
	logic [DQ_W-1:0]                 pfull;

	logic [PQ_W-1:0]                 pyd_q;
	logic [PQ_W-1:0]                 pquo_q;
	logic [lpd_pkg::PREM_W-1:0]      prem_q;
	logic [lpd_pkg::PDIG_W-1:0]      pdig_q;
	logic [lpd_pkg::PDV_W-1:0]       pdv;
	logic [PM_W-1:0]                 pmul;
	logic [lpd_pkg::PDV_W-1:0]       pback;

	logic [PW-1:0] press_q;
	logic          rsp_oor_q;
	logic          rsp_valid_q;

	logic start_query, fin_load;

	// ---------------------------------------------------------------- handshakes
	assign req.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign rsp.valid        = rsp_valid_q;
	assign rsp.pressure     = press_q;
	assign rsp.out_of_range = rsp_oor_q;

	assign start_query = req.valid && req.ready && (req.operation == lpd_pkg::OP_QUERY);
	assign fin_load    = (state_q == ST_FIN) && (!rsp_valid_q || rsp.ready);

	// ---------------------------------------------------------------- configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q <= lpd_pkg::ENTRIES_RESET;
			gravity_q <= lpd_pkg::GRAV_RESET;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				lpd_pkg::CFG_ENTRIES: entries_q <= cfg.data[lpd_pkg::ENTRIES_W-1:0];
				lpd_pkg::CFG_GRAVITY: gravity_q <= cfg.data[lpd_pkg::GRAV_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp the entry count to the table
	always_comb begin
		ent_w = 32'(entries_q);
		if (ent_w < 32'd2)
			live_n = CW'(2);
		else if (ent_w > 32'(TABLE_ENTRIES))
			live_n = CW'(TABLE_ENTRIES);
		else
			live_n = CW'(ent_w);
	end

	// ---------------------------------------------------------------- table memory
	assign wr_addr_wide = (AW + lpd_pkg::IDX_W)'(req.entry_index);
	assign wr_addr      = wr_addr_wide[AW-1:0];
	assign wr_en = req.valid && req.ready && (req.operation == lpd_pkg::OP_WRITE)
		&& (32'(req.entry_index) < 32'(TABLE_ENTRIES));

	always_ff @(posedge clk) begin
		if (wr_en)
			tbl_mem[wr_addr] <= {req.entry_depth, req.entry_density};
		if (rd_en)
			rd_data_q <= tbl_mem[rd_addr];
	end

	// ---------------------------------------------------------------- segment decode
	always_comb begin
		z1 = prev_q[lpd_pkg::ENTRY_W-1:RW];
		r1 = prev_q[RW-1:0];
		z2 = rd_data_q[lpd_pkg::ENTRY_W-1:RW];
		r2 = rd_data_q[RW-1:0];
		thick = (z2 > z1) ? (z2 - z1) : '0;
		span  = z2 - z1;
		dmag  = (r2 >= r1) ? (r2 - r1) : (r1 - r2);
		part_full   = q_q - QW'(z1);
		walk_found  = q_q < QW'(z2);
		walk_inside = q_q > QW'(z1);
		walk_last   = (nxt_q == live_n);
		// part < span here, so it fits the depth width
		ip_prod = IW'(part_full[DW-1:0]) * IW'(dmag);
	end

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		if (start_query) begin
			rd_en = 1'b1;
		end else if (state_q == ST_WALK) begin
			if (!have_prev_q || (!walk_found && !walk_last)) begin
				rd_en   = 1'b1;
				rd_addr = nxt_q[AW-1:0];
			end
		end
	end

	assign q_abs = req.query_depth[QW-1] ? (~req.query_depth + 1'b1) : req.query_depth;

	assign rq = up_q ? (r1_q + dq_q[RW-1:0]) : (r1_q - dq_q[RW-1:0]);

	always_comb begin
		prod_load = 1'b0;
		prod_d    = lpd_pkg::PROD_W'(thick) * lpd_pkg::PROD_W'({1'b0, r1} + {1'b0, r2});
		if (state_q == ST_WALK && have_prev_q && !walk_found)
			prod_load = 1'b1;
		if (state_q == ST_PART) begin
			prod_load = 1'b1;
			prod_d    = lpd_pkg::PROD_W'(part_q) * lpd_pkg::PROD_W'({1'b0, r1_q} + {1'b0, rq});
		end
	end

	// ---------------------------------------------------------------- interpolation divider step
	always_comb begin
		div_t    = {rem_q, dq_q[DQ_W-1]};
		div_ge   = div_t >= {1'b0, divr_q};
		div_diff = div_t - {1'b0, divr_q};
	end

	assign pfull = DQ_W'(plo_q) + (DQ_W'(phi_q) << LO_W);

	// one quotient digit of the odd divisor: reciprocal estimate, then the remainder
	always_comb begin
		pdv   = {prem_q, pyd_q[PQ_W-1 -: lpd_pkg::PDIG_W]};
		pmul  = PM_W'(pdv) * PM_W'(lpd_pkg::PRESS_RECIP);
		pback = lpd_pkg::PDV_W'(pdig_q) * lpd_pkg::PDV_W'(lpd_pkg::PRESS_ODD);
	end

	// ---------------------------------------------------------------- control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			have_prev_q <= 1'b0;
			nxt_q       <= '0;
			cnt_q       <= '0;
			oor_q       <= 1'b0;
			prod_vld_s1 <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			prod_vld_s1 <= prod_load;
			if (fin_load)
				rsp_valid_q <= 1'b1;
			else if (rsp.ready)
				rsp_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (start_query) begin
						state_q     <= ST_WALK;
						have_prev_q <= 1'b0;
						nxt_q       <= CW'(1);
						oor_q       <= 1'b0;
					end
				end
				ST_WALK: begin
					if (!have_prev_q) begin
						have_prev_q <= 1'b1;
						nxt_q       <= nxt_q + 1'b1;
					end else if (walk_found) begin
						if (walk_inside) begin
							state_q <= ST_DIV;
							cnt_q   <= CNT_W'(IW);
						end else begin
							state_q <= ST_SUMW;
						end
					end else if (walk_last) begin
						state_q <= ST_SUMW;
						oor_q   <= 1'b1;
					end else begin
						nxt_q <= nxt_q + 1'b1;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CNT_W'(1))
						state_q <= ST_PART;
				end
				ST_PART: state_q <= ST_SUMW;
				ST_SUMW: state_q <= ST_PMUL;
				ST_PMUL: state_q <= ST_PADD;
				ST_PADD: begin
					state_q <= ST_PDIV;
					cnt_q   <= CNT_W'(PD_N);
				end
				ST_PDIV: state_q <= ST_PREM;
				ST_PREM: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CNT_W'(1))
						state_q <= ST_FIN;
					else
						state_q <= ST_PDIV;
				end
				ST_FIN: begin
					if (fin_load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// ---------------------------------------------------------------- datapath
	always_ff @(posedge clk) begin
		if (prod_load)
			prod_s1 <= prod_d;

		// drain the product register into the area sum
		if (start_query)
			acc_q <= '0;
		else if (prod_vld_s1)
			acc_q <= acc_q + ACC_W'(prod_s1);

		if (start_query)
			q_q <= q_abs;

		if (state_q == ST_WALK)
			prev_q <= rd_data_q;

		if (state_q == ST_WALK && have_prev_q && walk_found && walk_inside) begin
			part_q <= part_full[DW-1:0];
			r1_q   <= r1;
			up_q   <= (r2 >= r1);
			dq_q   <= {ip_prod, (DQ_W - IW)'(0)};
			rem_q  <= '0;
			divr_q <= VW'(span);
		end

		if (state_q == ST_DIV) begin
			rem_q <= div_ge ? div_diff[VW-1:0] : div_t[VW-1:0];
			dq_q  <= {dq_q[DQ_W-2:0], div_ge};
		end

		if (state_q == ST_PMUL) begin
			plo_q <= (LO_W + lpd_pkg::GRAV_W)'(acc_q[LO_W-1:0])
				* (LO_W + lpd_pkg::GRAV_W)'(gravity_q);
			phi_q <= (HI_W + lpd_pkg::GRAV_W)'(acc_q[ACC_W-1:LO_W])
				* (HI_W + lpd_pkg::GRAV_W)'(gravity_q);
		end

		// drop the power-of-two part of the divisor up front
		if (state_q == ST_PADD) begin
			pyd_q  <= PQ_W'(pfull >> lpd_pkg::PRESS_SHIFT);
			prem_q <= '0;
			pquo_q <= '0;
		end

		if (state_q == ST_PDIV)
			pdig_q <= pmul[lpd_pkg::RECIP_SH +: lpd_pkg::PDIG_W];

		if (state_q == ST_PREM) begin
			prem_q <= lpd_pkg::PREM_W'(pdv - pback);
			pyd_q  <= pyd_q << lpd_pkg::PDIG_W;
			pquo_q <= {pquo_q[PQ_W-lpd_pkg::PDIG_W-1:0], pdig_q};
		end

		// saturate the quotient to the pressure width
		if (fin_load) begin
			press_q   <= (|pquo_q[PQ_W-1:PW]) ? '1 : pquo_q[PW-1:0];
			rsp_oor_q <= oor_q;
		end
	end

endmodule

`default_nettype wire
